@@ rtl/lsdf_pkg.sv @@
// lsdf_pkg: request and result types and fixed field widths of the sieve engine
// no dependencies; used by linear_sieve_divisor_functions and its testbench
package lsdf_pkg;

  localparam int unsigned IDX_W   = 12;  // query index, echo, min divisor, totient fields
  localparam int unsigned CNT_W   = 7;   // divisor count field and table
  localparam int unsigned SUM_W   = 15;  // divisor sum field and table
  localparam int unsigned PRIME_W = 11;  // primes found field

  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] query_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index_echo;
    logic [IDX_W-1:0]   smallest_divisor;
    logic [CNT_W-1:0]   divisor_count;
    logic [SUM_W-1:0]   divisor_sum;
    logic [IDX_W-1:0]   totient;
    logic [PRIME_W-1:0] primes_found;
    logic               out_of_range;
  } rsp_t;

endpackage

@@ rtl/lsdf_ram.sv @@
// lsdf_ram: generic single write port, single read port ram with registered read
// no dependencies
module lsdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/linear_sieve_divisor_functions.sv @@
// linear_sieve_divisor_functions: linear sieve engine with divisor count, sum and totient
// depends on lsdf_pkg (types, widths) and lsdf_ram (table storage)
//
// usage
//   in_* channel carries requests (valid/ready); req_type selects build or read
//   out_* channel returns one result per request (valid/ready), held in an
//   output register so a finished result may wait while the engine idles
//   cfg_we/cfg_wdata write sieve_limit; the user writes only while idle, not enforced
// sequence
//   read: R_ISS then R_DATA, which registers the result into out_* and returns to idle
//   build: a clear sweep of indices 0..L, then per index the states I_RD, I_CHK and
//   K_ISS, K_P over the prime list, plus M1 to M6 per composite it marks,
//   L = min(sieve_limit, MAX_N); one shared multiplier carries every product
//   in_ready is high only in idle; one request is worked on at a time
// reset
//   sieve_limit returns to 4095, no build is recorded, tables keep garbage;
//   reads before the first build report out_of_range
// stalls
//   a finished result waits in its state until out_ready frees the register
module linear_sieve_divisor_functions #(
  parameter int unsigned MAX_N          = 4095,
  parameter int unsigned PRIME_CAPACITY = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lsdf_pkg::req_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lsdf_pkg::rsp_t                 out_data,
  input  logic                           cfg_we,
  input  logic [lsdf_pkg::IDX_W-1:0]     cfg_wdata
);

  // index width covers 0..MAX_N; compare width covers both index and field
  localparam int unsigned NW   = $clog2(MAX_N + 1);
  localparam int unsigned CW   = (NW > lsdf_pkg::IDX_W) ? NW : lsdf_pkg::IDX_W;
  localparam int unsigned EW   = $clog2(NW + 1);
  localparam int unsigned OW   = (NW > lsdf_pkg::SUM_W) ? NW : lsdf_pkg::SUM_W;
  localparam int unsigned PW   = 2 * OW;
  localparam int unsigned KW   = $clog2(PRIME_CAPACITY + 1);
  localparam int unsigned PAW  = (PRIME_CAPACITY > 1) ? $clog2(PRIME_CAPACITY) : 1;
  localparam int unsigned SW   = lsdf_pkg::SUM_W;
  localparam int unsigned DW   = lsdf_pkg::CNT_W;
  localparam logic [CW-1:0] MAXN_C = CW'(MAX_N);
  localparam logic [KW-1:0] CAP_C  = KW'(PRIME_CAPACITY);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_NXT, ST_I_RD, ST_I_CHK, ST_K_ISS, ST_K_P,
    ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_FIN, ST_R_ISS, ST_R_DATA
  } state_t;

  state_t                  state_r, state_nxt;
  logic [lsdf_pkg::IDX_W-1:0] limit_r, limit_nxt;
  logic [NW:0]             i_r, i_nxt;
  logic [NW-1:0]           lim_r, lim_nxt, built_lim_r, built_lim_nxt;
  logic                    built_r, built_nxt;
  logic [KW-1:0]           cnt_r, cnt_nxt, k_r, k_nxt;
  logic [NW-1:0]           p_r, p_nxt, mdi_r, mdi_nxt, resti_r, resti_nxt, ppi_r, ppi_nxt;
  logic [EW-1:0]           ei_r, ei_nxt, e_r, e_nxt;
  logic [SW-1:0]           spi_r, spi_nxt, spc_r, spc_nxt, dsc_r, dsc_nxt;
  logic                    sel_r, sel_nxt;
  logic [NW-1:0]           c_r, c_nxt, base_r, base_nxt, pw_r, pw_nxt;
  logic [DW-1:0]           dcc_r, dcc_nxt;
  logic [OW-1:0]           ma_r, ma_nxt, mb_r, mb_nxt;
  logic [lsdf_pkg::IDX_W-1:0] q_r, q_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lsdf_pkg::rsp_t          out_r, out_nxt;

  logic [PW-1:0]           prod;
  logic                    out_free;
  logic [NW-1:0]           i_idx, q_idx;

  // table ram ports
  logic                    tw_en;
  logic [NW-1:0]           tw_addr, ra_addr, rb_addr;
  logic [NW-1:0]           md_wd, md_rd, rest_wd, rest_rd, pp_wd, pp_rd, tot_wd, tot_rd;
  logic [EW-1:0]           ex_wd, ex_rd;
  logic [SW-1:0]           sp_wd, sp_rd, ds_wd, ds_rd;
  logic [DW-1:0]           dc_wd, dc_rd;
  logic                    pl_we;
  logic [PAW-1:0]          pl_waddr, pl_raddr;
  logic [NW-1:0]           pl_wd, pl_rd;

  assign prod     = PW'(ma_r) * PW'(mb_r);
  assign out_free = !out_valid_r || out_ready;
  assign i_idx    = i_r[NW-1:0];
  assign q_idx    = NW'(q_r);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // address side a: per-index records of i; side b: records of the cofactor
  assign ra_addr  = (state_r == ST_R_ISS || state_r == ST_R_DATA) ? q_idx : i_idx;
  assign rb_addr  = (state_r == ST_R_ISS || state_r == ST_R_DATA) ? q_idx : base_r;
  assign pl_raddr = k_r[PAW-1:0];

  lsdf_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_md (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(md_wd), .raddr(ra_addr), .rdata(md_rd));
  lsdf_ram #(.WIDTH(EW), .DEPTH(MAX_N + 1)) u_ex (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(ex_wd), .raddr(ra_addr), .rdata(ex_rd));
  lsdf_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_rest (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(rest_wd), .raddr(ra_addr), .rdata(rest_rd));
  lsdf_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_pp (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(pp_wd), .raddr(ra_addr), .rdata(pp_rd));
  lsdf_ram #(.WIDTH(SW), .DEPTH(MAX_N + 1)) u_sp (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(sp_wd), .raddr(ra_addr), .rdata(sp_rd));
  lsdf_ram #(.WIDTH(DW), .DEPTH(MAX_N + 1)) u_dc (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(dc_wd), .raddr(rb_addr), .rdata(dc_rd));
  lsdf_ram #(.WIDTH(SW), .DEPTH(MAX_N + 1)) u_ds (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(ds_wd), .raddr(rb_addr), .rdata(ds_rd));
  lsdf_ram #(.WIDTH(NW), .DEPTH(MAX_N + 1)) u_tot (
    .clk, .we(tw_en), .waddr(tw_addr), .wdata(tot_wd), .raddr(rb_addr), .rdata(tot_rd));
  lsdf_ram #(.WIDTH(NW), .DEPTH(PRIME_CAPACITY)) u_pl (
    .clk, .we(pl_we), .waddr(pl_waddr), .wdata(pl_wd), .raddr(pl_raddr), .rdata(pl_rd));

  // table writes: clear sweep, new prime at i, composite at c
  always_comb begin
    tw_en    = 1'b0;
    tw_addr  = i_idx;
    md_wd    = '0;
    ex_wd    = '0;
    rest_wd  = NW'(1);
    pp_wd    = NW'(1);
    sp_wd    = SW'(1);
    dc_wd    = DW'(1);
    ds_wd    = SW'(1);
    tot_wd   = NW'(1);
    pl_we    = 1'b0;
    pl_waddr = cnt_r[PAW-1:0];
    pl_wd    = i_idx;
    unique case (state_r)
      ST_CLR: begin
        tw_en = 1'b1;
      end
      ST_I_CHK: begin
        if (md_rd == '0) begin
          tw_en  = 1'b1;
          md_wd  = i_idx;
          ex_wd  = EW'(1);
          pp_wd  = i_idx;
          sp_wd  = SW'(i_idx) + SW'(1);
          dc_wd  = DW'(2);
          ds_wd  = SW'(i_idx) + SW'(1);
          tot_wd = i_idx - NW'(1);
          pl_we  = (cnt_r < CAP_C);
        end
      end
      ST_M6: begin
        tw_en   = 1'b1;
        tw_addr = c_r;
        md_wd   = p_r;
        ex_wd   = e_r;
        rest_wd = base_r;
        pp_wd   = pw_r;
        sp_wd   = spc_r;
        dc_wd   = dcc_r;
        ds_wd   = dsc_r;
        tot_wd  = prod[NW-1:0];
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    i_nxt         = i_r;
    lim_nxt       = lim_r;
    built_lim_nxt = built_lim_r;
    built_nxt     = built_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    mdi_nxt       = mdi_r;
    resti_nxt     = resti_r;
    ppi_nxt       = ppi_r;
    ei_nxt        = ei_r;
    e_nxt         = e_r;
    spi_nxt       = spi_r;
    spc_nxt       = spc_r;
    dsc_nxt       = dsc_r;
    sel_nxt       = sel_r;
    c_nxt         = c_r;
    base_nxt      = base_r;
    pw_nxt        = pw_r;
    dcc_nxt       = dcc_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          q_nxt = in_data.query_index;
          if (in_data.req_type == lsdf_pkg::REQ_READ) begin
            state_nxt = ST_R_ISS;
          end else begin
            // coverage limited to MAX_N
            lim_nxt   = (CW'(limit_r) > MAXN_C) ? NW'(MAX_N) : NW'(limit_r);
            i_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        if (i_idx == lim_r) begin
          i_nxt     = (NW + 1)'(2);
          k_nxt     = '0;
          state_nxt = (lim_r < NW'(2)) ? ST_FIN : ST_I_RD;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_NXT: begin
        k_nxt = '0;
        if (i_r == (NW + 1)'(lim_r)) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_I_RD;
        end
      end
      ST_I_RD: begin
        state_nxt = ST_I_CHK;
      end
      ST_I_CHK: begin
        if (md_rd == '0) begin
          // new prime: its own record, listed while there is room
          mdi_nxt   = i_idx;
          ei_nxt    = EW'(1);
          resti_nxt = NW'(1);
          ppi_nxt   = i_idx;
          spi_nxt   = SW'(i_idx) + SW'(1);
          if (cnt_r < CAP_C) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          mdi_nxt   = md_rd;
          ei_nxt    = ex_rd;
          resti_nxt = rest_rd;
          ppi_nxt   = pp_rd;
          spi_nxt   = sp_rd;
        end
        state_nxt = ST_K_ISS;
      end
      ST_K_ISS: begin
        state_nxt = (k_r >= cnt_r) ? ST_NXT : ST_K_P;
      end
      ST_K_P: begin
        p_nxt = pl_rd;
        if (pl_rd > mdi_r) begin
          state_nxt = ST_NXT;
        end else begin
          ma_nxt    = OW'(pl_rd);
          mb_nxt    = OW'(i_idx);
          state_nxt = ST_M1;
        end
      end
      ST_M1: begin
        // c = p * i
        if (prod > PW'(lim_r)) begin
          state_nxt = ST_NXT;
        end else begin
          c_nxt     = prod[NW-1:0];
          sel_nxt   = (p_r == mdi_r);
          base_nxt  = (p_r == mdi_r) ? resti_r : i_idx;
          e_nxt     = (p_r == mdi_r) ? ei_r + EW'(1) : EW'(1);
          ma_nxt    = OW'(ppi_r);
          mb_nxt    = OW'(p_r);
          state_nxt = ST_M2;
        end
      end
      ST_M2: begin
        // prime power of the smallest divisor in c
        pw_nxt    = sel_r ? prod[NW-1:0] : p_r;
        ma_nxt    = OW'(spi_r);
        mb_nxt    = OW'(p_r);
        state_nxt = ST_M3;
      end
      ST_M3: begin
        // divisor sum of that prime power, cofactor records now on side b
        spc_nxt   = sel_r ? SW'(prod[SW-1:0] + SW'(1)) : SW'(p_r) + SW'(1);
        ma_nxt    = OW'(dc_rd);
        mb_nxt    = OW'(e_r) + OW'(1);
        state_nxt = ST_M4;
      end
      ST_M4: begin
        dcc_nxt   = prod[DW-1:0];
        ma_nxt    = OW'(ds_rd);
        mb_nxt    = OW'(spc_r);
        state_nxt = ST_M5;
      end
      ST_M5: begin
        dsc_nxt   = prod[SW-1:0];
        ma_nxt    = OW'(tot_rd);
        mb_nxt    = sel_r ? OW'(pw_r - ppi_r) : OW'(p_r - NW'(1));
        state_nxt = ST_M6;
      end
      ST_M6: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = ST_K_ISS;
      end
      ST_FIN: begin
        built_nxt     = 1'b1;
        built_lim_nxt = lim_r;
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.primes_found = lsdf_pkg::PRIME_W'(cnt_r);
          state_nxt            = ST_IDLE;
        end
      end
      ST_R_ISS: begin
        state_nxt = ST_R_DATA;
      end
      ST_R_DATA: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.index_echo   = q_r;
          out_nxt.primes_found = lsdf_pkg::PRIME_W'(cnt_r);
          if (!built_r || CW'(q_r) > CW'(built_lim_r) || q_r > limit_r) begin
            out_nxt.out_of_range = 1'b1;
          end else begin
            out_nxt.smallest_divisor = lsdf_pkg::IDX_W'(md_rd);
            out_nxt.divisor_count    = dc_rd;
            out_nxt.divisor_sum      = ds_rd;
            out_nxt.totient          = lsdf_pkg::IDX_W'(tot_rd);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= lsdf_pkg::IDX_W'(4095);
      built_r     <= 1'b0;
      built_lim_r <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      built_r     <= built_nxt;
      built_lim_r <= built_lim_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lim_r   <= lim_nxt;
    p_r     <= p_nxt;
    mdi_r   <= mdi_nxt;
    resti_r <= resti_nxt;
    ppi_r   <= ppi_nxt;
    ei_r    <= ei_nxt;
    e_r     <= e_nxt;
    spi_r   <= spi_nxt;
    spc_r   <= spc_nxt;
    dsc_r   <= dsc_nxt;
    sel_r   <= sel_nxt;
    c_r     <= c_nxt;
    base_r  <= base_nxt;
    pw_r    <= pw_nxt;
    dcc_r   <= dcc_nxt;
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    q_r     <= q_nxt;
    out_r   <= out_nxt;
  end

endmodule

@@ sim/tb_linear_sieve_divisor_functions.sv @@
// testbench for linear_sieve_divisor_functions: directed and random build/read requests
// checked against a local sieve predictor; depends on lsdf_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_linear_sieve_divisor_functions;

  localparam int unsigned SIEVE_MAX     = 4095;
  localparam int unsigned PRIME_CAP     = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 400000;  // watchdog bound on quiet cycles
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  lsdf_pkg::req_t in_data;
  logic out_valid;
  logic out_ready;
  lsdf_pkg::rsp_t out_data;
  logic cfg_we;
  logic [lsdf_pkg::IDX_W-1:0] cfg_wdata;

  // predictor state: tables of the last build plus the register copy
  int unsigned spf_tbl [0:SIEVE_MAX];
  int unsigned ndiv_tbl [0:SIEVE_MAX];
  int unsigned sdiv_tbl [0:SIEVE_MAX];
  int unsigned phi_tbl [0:SIEVE_MAX];
  int unsigned spf_exp_tbl [0:SIEVE_MAX];
  int unsigned prime_tbl [0:PRIME_CAP-1];
  int unsigned prime_cnt;
  bit          tables_valid;
  int unsigned tables_limit;
  int unsigned limit_reg;

  lsdf_pkg::rsp_t expected_rsp_q[$];
  int unsigned error_count;
  int unsigned quiet_cycles;
  bit          idling_on;

  linear_sieve_divisor_functions i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // linear sieve over 2..lim, every composite marked once by its smallest prime
  function automatic void sieve_tables();
    int unsigned lim;
    int unsigned p;
    int unsigned c;
    int unsigned e;
    longint unsigned pw;
    int unsigned base;
    lim = (limit_reg > SIEVE_MAX) ? SIEVE_MAX : limit_reg;
    for (int n = 0; n <= SIEVE_MAX; n++) spf_tbl[n] = 0;
    for (int n = 0; n <= lim; n++) begin
      ndiv_tbl[n]    = 1;
      sdiv_tbl[n]    = 1;
      phi_tbl[n]     = 1;
      spf_exp_tbl[n] = 0;
    end
    prime_cnt = 0;
    for (int unsigned i = 2; i <= lim; i++) begin
      if (spf_tbl[i] == 0) begin
        // prime list full: the prime keeps its values but sieves nothing
        if (prime_cnt < PRIME_CAP) begin
          prime_tbl[prime_cnt] = i;
          prime_cnt++;
        end
        spf_tbl[i]     = i;
        ndiv_tbl[i]    = 2;
        sdiv_tbl[i]    = i + 1;
        phi_tbl[i]     = i - 1;
        spf_exp_tbl[i] = 1;
      end
      for (int unsigned k = 0; k < prime_cnt; k++) begin
        p = prime_tbl[k];
        c = p * i;
        if (p > spf_tbl[i] || c > lim) break;
        spf_tbl[c] = p;
        e = 1 + ((p == spf_tbl[i]) ? spf_exp_tbl[i] : 0);
        spf_exp_tbl[c] = e;
        pw = 1;
        for (int unsigned j = 0; j < e; j++) pw = pw * p;
        base = 32'(c / pw);
        ndiv_tbl[c] = ndiv_tbl[base] * (1 + e);
        sdiv_tbl[c] = 32'(longint'(sdiv_tbl[base]) * (pw * p - 1) / (p - 1));
        phi_tbl[c]  = 32'(longint'(phi_tbl[base]) * (pw - pw / p));
      end
    end
    tables_limit = lim;
    tables_valid = 1'b1;
  endfunction

  function automatic lsdf_pkg::rsp_t predict_rsp(lsdf_pkg::req_t r);
    lsdf_pkg::rsp_t rsp;
    rsp = '0;
    if (r.req_type == lsdf_pkg::REQ_BUILD) begin
      sieve_tables();
      rsp.primes_found = prime_cnt[lsdf_pkg::PRIME_W-1:0];
      return rsp;
    end
    rsp.index_echo   = r.query_index;
    rsp.primes_found = prime_cnt[lsdf_pkg::PRIME_W-1:0];
    // no build yet, or index beyond the built range or the current limit
    if (!tables_valid || r.query_index > tables_limit || r.query_index > limit_reg) begin
      rsp.out_of_range = 1'b1;
      return rsp;
    end
    rsp.smallest_divisor = spf_tbl[r.query_index][lsdf_pkg::IDX_W-1:0];
    rsp.divisor_count    = ndiv_tbl[r.query_index][lsdf_pkg::CNT_W-1:0];
    rsp.divisor_sum      = sdiv_tbl[r.query_index][lsdf_pkg::SUM_W-1:0];
    rsp.totient          = phi_tbl[r.query_index][lsdf_pkg::IDX_W-1:0];
    return rsp;
  endfunction

  function automatic bit idle_roll();
    return idling_on && ($urandom_range(99) < 38);
  endfunction

  // drive one request; returns at the edge where it is taken, valid left high
  task automatic send_req(logic kind, logic [lsdf_pkg::IDX_W-1:0] idx);
    lsdf_pkg::req_t r;
    lsdf_pkg::rsp_t exp_rsp;
    r.req_type    = kind;
    r.query_index = idx;
    @(negedge clk);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      in_data  <= lsdf_pkg::req_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    exp_rsp = predict_rsp(r);
    expected_rsp_q = {expected_rsp_q, exp_rsp};
  endtask

  task automatic read_idx(int unsigned idx);
    send_req(lsdf_pkg::REQ_READ, idx[lsdf_pkg::IDX_W-1:0]);
  endtask

  task automatic build_tables();
    send_req(lsdf_pkg::REQ_BUILD, lsdf_pkg::IDX_W'($urandom));
  endtask

  // drop valid and wait for every outstanding result; set_limit then writes the limit while idle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned lim);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim[lsdf_pkg::IDX_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_reg = lim;
  endtask

  // reads before the first build all report out of range
  task automatic test_read_before_build();
    read_idx(0);
    read_idx(1);
    read_idx(SIEVE_MAX);
    read_idx(12'hAAA);
  endtask

  // full-size build at the reset limit, then corner indices
  task automatic test_full_build();
    build_tables();
    read_idx(0);
    read_idx(1);
    read_idx(2);
    read_idx(4093);          // largest prime in range
    read_idx(SIEVE_MAX);
    read_idx(2048);          // high power of two
    read_idx(2520);          // many divisors
    read_idx(3840);
    read_idx(12'h555);
  endtask

  // tiny limits, and a lowered limit without rebuilding
  task automatic test_limit_extremes();
    set_limit(0);
    read_idx(5);             // old tables, but above the new limit
    build_tables();
    read_idx(0);
    read_idx(1);
    set_limit(1);
    build_tables();
    read_idx(1);
    read_idx(2);
    set_limit(2);
    build_tables();
    read_idx(2);
    read_idx(3);
  endtask

  // random limits; mostly in-range reads with occasional rebuilds
  task automatic test_random_phases();
    int unsigned lim;
    for (int ph = 0; ph < 10; ph++) begin
      idling_on = !(ph == 3 || ph == 4);
      lim = (ph == 9) ? SIEVE_MAX : $urandom_range(400, 2);
      set_limit(lim);
      if (ph != 5) build_tables();   // phase 5 reads old tables against a new limit
      for (int n = 0; n < 130; n++) begin
        if ($urandom_range(99) < 4) build_tables();
        else if ($urandom_range(99) < 70) read_idx($urandom_range(lim, 0));
        else read_idx($urandom_range(SIEVE_MAX, 0));
      end
    end
    idling_on = 1'b1;
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // result side: random back-pressure at negedge, compare at posedge
  always @(negedge clk) begin
    if (rst_n) out_ready <= !idle_roll();
  end

  always @(posedge clk) begin
    lsdf_pkg::rsp_t exp_rsp;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $realtime, out_data);
          error_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          check_field("index_echo", exp_rsp.index_echo, out_data.index_echo);
          check_field("smallest_divisor", exp_rsp.smallest_divisor, out_data.smallest_divisor);
          check_field("divisor_count", exp_rsp.divisor_count, out_data.divisor_count);
          check_field("divisor_sum", exp_rsp.divisor_sum, out_data.divisor_sum);
          check_field("totient", exp_rsp.totient, out_data.totient);
          check_field("primes_found", exp_rsp.primes_found, out_data.primes_found);
          check_field("out_of_range", exp_rsp.out_of_range, out_data.out_of_range);
        end
      end
    end
  end

  // watchdog: too long with nothing accepted on either channel
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    error_count  = 0;
    quiet_cycles = 0;
    idling_on    = 1'b1;
    limit_reg    = SIEVE_MAX;
    prime_cnt    = 0;
    tables_valid = 1'b0;
    tables_limit = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_read_before_build();
    test_full_build();
    test_limit_extremes();
    test_random_phases();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
